// ----- rtl/bsir_pkg.sv -----
`default_nettype none

package bsir_pkg;

  localparam int DATA_W = 8;
  localparam int POS_W  = 8;
  localparam int OCC_W  = 5;
  localparam int CMD_W  = 2;

  localparam logic [CMD_W-1:0] CMD_PUSH   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_POP    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd3;

endpackage

`default_nettype wire

// ----- rtl/bsir_ram.sv -----
`default_nettype none

module bsir_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                 clk,
  input  wire logic                                 we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                     wdata,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- rtl/byte_stack_indexed_removal.sv -----
`default_nettype none
// Byte stack with removal at any depth.
// Requests arrive on the in_* channel (command, push_value, position) and each one
// gives exactly one response on the out_* channel (popped_value, failed, occupancy).
// The block handles one request at a time: in_ready is high only while it is idle,
// and it stays low until the response has been taken by the receiver.
// When the response becomes valid:
//   push, clear, or any request that fails: in the cycle after it is taken.
//   pop: after one registered read of the entry RAM (state S_CAPT).
//   remove at depth p: after that read, the p entries above the removed one are moved
//   down one place per cycle through the RAM's one read port and one write port (S_SHIFT).
// Each request keeps the block busy until its response has been taken, longer if the
// receiver stalls; while out_ready is low the response is held unchanged and no new
// request is taken.
// Reset empties the stack (occupancy 0); the entry RAM is not cleared, as only
// entries below the occupancy are ever read.
// DEPTH sets the number of entries; occupancy reports the low five bits of the count.

module byte_stack_indexed_removal #(
  parameter int DEPTH = 16
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [bsir_pkg::CMD_W-1:0]   command,
  input  wire logic [bsir_pkg::DATA_W-1:0]  push_value,
  input  wire logic [bsir_pkg::POS_W-1:0]   position,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic      [bsir_pkg::DATA_W-1:0]  popped_value,
  output logic                              failed,
  output logic      [bsir_pkg::OCC_W-1:0]   occupancy
);

  import bsir_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int WW = (CW > POS_W) ? CW : POS_W;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_CAPT  = 4'b0010,
    S_SHIFT = 4'b0100,
    S_RESP  = 4'b1000
  } state_t;

  state_t            state, state_next;
  logic [CW-1:0]     count, count_next;
  logic [AW-1:0]     ptr, ptr_next;
  logic [DATA_W-1:0] value, value_next;
  logic              fail_reg, fail_next;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [DATA_W-1:0] ram_wdata;
  logic [AW-1:0]     ram_raddr;
  logic [DATA_W-1:0] ram_rdata;

  logic [WW-1:0]     ext_pos;
  logic [WW-1:0]     ext_cnt;
  logic [WW-1:0]     slot;
  logic [AW:0]       ptr_plus2;
  logic [CW:0]       ptr_plus1;
  logic [CW+OCC_W-1:0] occ_ext;

  bsir_ram #(
    .WIDTH(DATA_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_comb begin
    // A pop is a removal at depth zero.
    ext_pos   = (command == CMD_POP) ? '0 : WW'(position);
    ext_cnt   = WW'(count);
    slot      = ext_cnt - WW'(1) - ext_pos;
    ptr_plus2 = (AW + 1)'(ptr) + (AW + 1)'(2);
    ptr_plus1 = (CW + 1)'(ptr) + (CW + 1)'(1);

    state_next = state;
    count_next = count;
    ptr_next   = ptr;
    value_next = value;
    fail_next  = fail_reg;
    ram_we     = 1'b0;
    ram_waddr  = ptr;
    ram_wdata  = ram_rdata;
    ram_raddr  = slot[AW-1:0];

    case (state)
      S_IDLE: begin
        if (in_valid) begin
          value_next = '0;
          fail_next  = 1'b0;
          state_next = S_RESP;
          case (command)
            CMD_PUSH: begin
              if (count == CW'(DEPTH)) begin
                fail_next = 1'b1;
              end else begin
                ram_we     = 1'b1;
                ram_waddr  = count[AW-1:0];
                ram_wdata  = push_value;
                count_next = count + CW'(1);
              end
            end
            CMD_POP, CMD_REMOVE: begin
              if (ext_pos >= ext_cnt) begin
                fail_next = 1'b1;
              end else begin
                ptr_next   = slot[AW-1:0];
                count_next = count - CW'(1);
                state_next = S_CAPT;
              end
            end
            CMD_CLEAR: begin
              count_next = '0;
            end
            default: begin
              fail_next = 1'b1;
            end
          endcase
        end
      end
      S_CAPT: begin
        value_next = ram_rdata;
        // Entries above the removed slot move down one place each.
        if (CW'(ptr) < count) begin
          ram_raddr  = ptr_plus2[AW-1:0] - AW'(1);
          state_next = S_SHIFT;
        end else begin
          state_next = S_RESP;
        end
      end
      S_SHIFT: begin
        ram_we    = 1'b1;
        ram_waddr = ptr;
        ram_wdata = ram_rdata;
        if (ptr_plus1 < (CW + 1)'(count)) begin
          ram_raddr = ptr_plus2[AW-1:0];
          ptr_next  = ptr + AW'(1);
        end else begin
          state_next = S_RESP;
        end
      end
      S_RESP: begin
        if (out_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
    ptr      <= ptr_next;
    value    <= value_next;
    fail_reg <= fail_next;
  end

  assign occ_ext      = (CW + OCC_W)'(count);
  assign in_ready     = (state == S_IDLE);
  assign out_valid    = (state == S_RESP);
  assign popped_value = value;
  assign failed       = fail_reg;
  assign occupancy    = occ_ext[OCC_W-1:0];

endmodule

`default_nettype wire

// ----- rtl/bsir_checker.sv -----
`default_nettype none

module bsir_checker (
  input wire logic                        clk,
  input wire logic                        rst,
  input wire logic                        in_valid,
  input wire logic                        in_ready,
  input wire logic [bsir_pkg::CMD_W-1:0]  command,
  input wire logic                        out_valid,
  input wire logic                        out_ready,
  input wire logic [bsir_pkg::DATA_W-1:0] popped_value,
  input wire logic                        failed,
  input wire logic [bsir_pkg::OCC_W-1:0]  occupancy
);

  import bsir_pkg::*;

  // Only one request is in flight, so the two sides are never open together.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("request taken while a response is pending");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("ready stayed high after a request was taken");

  a_single_response: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready) |=> !out_valid)
    else $error("more than one response for a request");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && failed) |-> (popped_value == '0))
    else $error("failed response carries a value");

  a_clear_empty: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && command == CMD_CLEAR) |=>
      (out_valid && !failed && occupancy == '0))
    else $error("clear did not empty the stack");

endmodule

bind byte_stack_indexed_removal bsir_checker u_bsir_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .command     (command),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .popped_value(popped_value),
  .failed      (failed),
  .occupancy   (occupancy)
);

`default_nettype wire

// ----- dv/bsir_response_checker.sv -----
`timescale 1ns / 1ps

module bsir_response_checker #(
  parameter int DEPTH = 16
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  input  wire logic                         in_ready,
  input  wire logic [bsir_pkg::CMD_W-1:0]   command,
  input  wire logic [bsir_pkg::DATA_W-1:0]  push_value,
  input  wire logic [bsir_pkg::POS_W-1:0]   position,
  input  wire logic                         out_valid,
  input  wire logic                         out_ready,
  input  wire logic [bsir_pkg::DATA_W-1:0]  popped_value,
  input  wire logic                         failed,
  input  wire logic [bsir_pkg::OCC_W-1:0]   occupancy,
  output int                                failures,
  output int                                outstanding
);

  import bsir_pkg::*;

  typedef struct packed {
    logic [DATA_W-1:0] value;
    logic              failed_bit;
    logic [OCC_W-1:0]  occ;
  } stack_response_t;

  // Slot 0 is the bottom of the stack and slot held_count-1 the top.
  logic [DATA_W-1:0] held_bytes [DEPTH];
  int                held_count = 0;
  stack_response_t   awaited_responses [$];
  int                mismatch_total = 0;

  task automatic apply_stack_command(input logic [CMD_W-1:0] cmd,
                                     input logic [DATA_W-1:0] pv,
                                     input logic [POS_W-1:0] pos,
                                     output stack_response_t rsp);
    int slot;
    int k;
    rsp = '0;
    case (cmd)
      CMD_PUSH: begin
        if (held_count >= DEPTH) begin
          rsp.failed_bit = 1'b1;
        end else begin
          held_bytes[held_count] = pv;
          held_count++;
        end
      end
      CMD_POP: begin
        if (held_count == 0) begin
          rsp.failed_bit = 1'b1;
        end else begin
          held_count--;
          rsp.value = held_bytes[held_count];
        end
      end
      CMD_REMOVE: begin
        if (int'(pos) >= held_count) begin
          rsp.failed_bit = 1'b1;
        end else begin
          // The entries above the removed one drop down to close the gap.
          slot = held_count - 1 - int'(pos);
          rsp.value = held_bytes[slot];
          for (k = slot; k + 1 < held_count; k++) begin
            held_bytes[k] = held_bytes[k + 1];
          end
          held_count--;
        end
      end
      default: begin
        held_count = 0;
      end
    endcase
    rsp.occ = held_count[OCC_W-1:0];
  endtask

  always @(posedge clk) begin : watch
    stack_response_t want;
    stack_response_t fresh;
    if (rst) begin
      held_count = 0;
      awaited_responses.delete();
    end else begin
      // A response always belongs to an earlier request, so it is checked first.
      if (out_valid && out_ready) begin
        if (awaited_responses.size() == 0) begin
          $error("response with no request outstanding");
          mismatch_total++;
        end else begin
          want = awaited_responses.pop_front();
          if (popped_value !== want.value) begin
            $error("popped_value: expected %0d, got %0d", want.value, popped_value);
            mismatch_total++;
          end
          if (failed !== want.failed_bit) begin
            $error("failed: expected %0d, got %0d", want.failed_bit, failed);
            mismatch_total++;
          end
          if (occupancy !== want.occ) begin
            $error("occupancy: expected %0d, got %0d", want.occ, occupancy);
            mismatch_total++;
          end
        end
      end
      if (in_valid && in_ready) begin
        apply_stack_command(command, push_value, position, fresh);
        awaited_responses.push_back(fresh);
      end
    end
    failures    <= mismatch_total;
    outstanding <= awaited_responses.size();
  end

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;

  import bsir_pkg::*;

  localparam int DEPTH      = 16;
  localparam int ITEMS      = 1150;
  localparam int IDLE_LIMIT = 2000;

  logic                clk;
  logic                rst        = 1'b1;
  logic                in_valid   = 1'b0;
  logic                out_ready  = 1'b0;
  logic [CMD_W-1:0]    command    = CMD_PUSH;
  logic [DATA_W-1:0]   push_value = '0;
  logic [POS_W-1:0]    position   = '0;
  wire                 in_ready;
  wire                 out_valid;
  wire  [DATA_W-1:0]   popped_value;
  wire                 failed;
  wire  [OCC_W-1:0]    occupancy;
  int                  failures;
  int                  outstanding;

  bit steady      = 1'b0;
  int depth_hint  = 0;
  int stall_left  = 0;
  int quiet_count = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  byte_stack_indexed_removal #(.DEPTH(DEPTH)) DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .command(command), .push_value(push_value), .position(position),
    .out_valid(out_valid), .out_ready(out_ready),
    .popped_value(popped_value), .failed(failed), .occupancy(occupancy)
  );

  bsir_response_checker #(.DEPTH(DEPTH)) response_check (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .command(command), .push_value(push_value), .position(position),
    .out_valid(out_valid), .out_ready(out_ready),
    .popped_value(popped_value), .failed(failed), .occupancy(occupancy),
    .failures(failures), .outstanding(outstanding)
  );

  // Mostly no gap or a short one, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  always @(posedge clk) begin
    int g;
    if (rst) begin
      out_ready  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!steady && $urandom_range(0, 3) == 0) begin
      g = pick_gap();
      out_ready  <= (g == 0);
      stall_left <= (g > 0) ? g - 1 : 0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_count <= 0;
      end else begin
        quiet_count <= quiet_count + 1;
      end
      if (quiet_count >= IDLE_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  task automatic send_request(input logic [CMD_W-1:0] c, input logic [DATA_W-1:0] v,
                              input logic [POS_W-1:0] p);
    int gap;
    gap = steady ? 0 : pick_gap();
    in_valid   <= 1'b1;
    command    <= c;
    push_value <= v;
    position   <= p;
    do @(posedge clk); while (!in_ready);
    // Rough count of entries, kept only to steer the random commands.
    case (c)
      CMD_PUSH:   if (depth_hint < DEPTH) depth_hint++;
      CMD_POP:    if (depth_hint > 0) depth_hint--;
      CMD_REMOVE: if (int'(p) < depth_hint) depth_hint--;
      default:    depth_hint = 0;
    endcase
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Holds the sender back until every request has had its response.
  task automatic drain_responses();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  initial begin
    int sent;
    int mode;
    int push_w;
    int r;
    logic [CMD_W-1:0]  c;
    logic [DATA_W-1:0] v;
    logic [POS_W-1:0]  p;

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Errors on an empty stack, then a removal at the bottom and a pop.
    send_request(CMD_POP, 8'h00, 8'h00);
    send_request(CMD_REMOVE, 8'hFF, 8'h00);
    send_request(CMD_CLEAR, 8'h5A, 8'hFF);
    send_request(CMD_PUSH, 8'hFF, 8'h00);
    send_request(CMD_PUSH, 8'h00, 8'hFF);
    send_request(CMD_REMOVE, 8'hA5, 8'h01);
    send_request(CMD_POP, 8'h3C, 8'h00);
    // Fill to the brim, push once more, then remove at the deepest slot.
    for (int i = 0; i < DEPTH; i++) begin
      send_request(CMD_PUSH, 8'(i * 17), 8'(i));
    end
    send_request(CMD_PUSH, 8'hC3, 8'h00);
    send_request(CMD_REMOVE, 8'h00, 8'(DEPTH - 1));
    send_request(CMD_REMOVE, 8'h00, 8'hFF);
    send_request(CMD_REMOVE, 8'h00, 8'h00);
    send_request(CMD_CLEAR, 8'h00, 8'h00);
    drain_responses();

    sent = 0;
    while (sent < ITEMS) begin
      mode   = $urandom_range(0, 2);
      push_w = (mode == 0) ? 70 : (mode == 1) ? 25 : 45;
      steady <= ($urandom_range(0, 3) == 0);
      repeat ($urandom_range(20, 60)) begin
        v = 8'($urandom_range(0, 255));
        p = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 99) < 8) begin
          c = CMD_W'($urandom_range(0, 3));
        end else begin
          r = $urandom_range(0, 99);
          if (r < 2) begin
            c = CMD_CLEAR;
          end else if (r < push_w) begin
            c = CMD_PUSH;
          end else if (r < push_w + (100 - push_w) / 3) begin
            c = CMD_POP;
          end else begin
            c = CMD_REMOVE;
            if (depth_hint > 0 && $urandom_range(0, 9) != 0) begin
              p = 8'($urandom_range(0, depth_hint - 1));
            end
          end
        end
        send_request(c, v, p);
        sent++;
      end
      if ($urandom_range(0, 4) == 0) begin
        drain_responses();
      end
    end

    drain_responses();
    repeat (20) @(posedge clk);
    if (failures == 0 && outstanding == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
